FILE: rtl/core/updd_pkg.sv
// ----------------------------------------------------------------------------
// updd_pkg
// Shared types and constants for the UART protocol detector and deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package updd_pkg;

    // input operations
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_SEND = 2'd1;
    localparam logic [1:0] OP_RX   = 2'd2;

    // protocol codes, also used by the mode register
    localparam logic [1:0] PROTO_NONE = 2'd0;
    localparam logic [1:0] PROTO_I    = 2'd1;
    localparam logic [1:0] PROTO_S    = 2'd2;

    // probe phases
    localparam logic [1:0] PHASE_NONE   = 2'd0;
    localparam logic [1:0] PHASE_I_SENT = 2'd1;
    localparam logic [1:0] PHASE_S_SENT = 2'd2;

    // configuration register indexes
    localparam logic CFG_MODE    = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

    localparam logic [7:0] REJ_FIRST   = 8'h15;
    localparam logic [7:0] REJ_SECOND  = 8'hEA;
    localparam logic [7:0] I_HEADER    = 8'h40;
    localparam logic [7:0] S_REG_SHORT_A = 8'h50;
    localparam logic [7:0] S_REG_SHORT_B = 8'h56;
    localparam logic [7:0] S_REG_53    = 8'h53;
    localparam logic [7:0] S_REG_54    = 8'h54;
    localparam logic [7:0] S_REG_55    = 8'h55;
    localparam logic [8:0] S_SHORT_LEN = 9'd6;
    localparam logic [8:0] S_LONG_LEN  = 9'd18;
    localparam logic [8:0] I_MIN_LEN   = 9'd3;

    typedef enum logic [2:0] {
        EV_PROBE_I  = 3'd0,
        EV_PROBE_S  = 3'd1,
        EV_RESOLVED = 3'd2,
        EV_BYTE     = 3'd3,
        EV_REJECT   = 3'd4,
        EV_HDR_ERR  = 3'd5
    } updd_event_t;

    typedef struct packed {
        updd_event_t ev;
        logic [1:0]  proto;
        logic [7:0]  registry;
        logic [7:0]  data;
        logic [8:0]  index;
        logic        last;
    } updd_res_t;

endpackage

`default_nettype wire

FILE: rtl/core/uart_protocol_detect_deframer_top.sv
// ----------------------------------------------------------------------------
// uart_protocol_detect_deframer_top
// UART protocol auto-detect and frame splitter with valid/ready channels.
// ----------------------------------------------------------------------------
// Takes one word per clock cycle while in_ready is high. Each accepted word sits
// in an input register, is decided by one pass of logic in updd_engine and lands
// in the result register, from which the result is presented, and at most one
// result comes from each word. Ticks, ignored send slots and
// absorbed header bytes give no result. While a result waits for out_ready the
// input register takes one more word, then in_ready drops until the result
// leaves. Write cfg_* only while no word is in flight.
`default_nettype none

module uart_protocol_detect_deframer_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       event_res,
    output logic [1:0]       protocol_now,
    output logic [7:0]       registry_id,
    output logic [7:0]       frame_data,
    output logic [8:0]       byte_index,
    output logic             frame_last,
    input  wire logic        cfg_write,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);
    import updd_pkg::*;

    logic        in_valid_reg;
    logic [1:0]  op_reg;
    logic [7:0]  byte_reg;
    logic [1:0]  mode_reg;
    logic [15:0] timeout_reg;
    logic        out_valid_reg, out_valid_next;
    updd_res_t   res_reg;
    updd_res_t   res;
    logic        res_valid;
    logic        fire;
    logic        mode_write;

    assign fire       = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !in_valid_reg || fire;
    assign mode_write = cfg_write && cfg_index == CFG_MODE;

    updd_engine u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .op         (op_reg),
        .rx_byte    (byte_reg),
        .mode       (mode_reg),
        .timeout    (timeout_reg),
        .mode_write (mode_write),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (fire)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= PROTO_NONE;
            timeout_reg   <= TIMEOUT_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            out_valid_reg <= out_valid_next;
            if (mode_write)
            begin
                mode_reg <= cfg_data[1:0];
            end
            if (cfg_write && cfg_index == CFG_TIMEOUT)
            begin
                timeout_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            op_reg   <= op;
            byte_reg <= rx_byte;
        end
        if (fire && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_res    = res_reg.ev;
    assign protocol_now = res_reg.proto;
    assign registry_id  = res_reg.registry;
    assign frame_data   = res_reg.data;
    assign byte_index   = res_reg.index;
    assign frame_last   = res_reg.last;

endmodule

`default_nettype wire

FILE: rtl/core/updd_engine.sv
// ----------------------------------------------------------------------------
// updd_engine
// Detection and framing state with the single-pass decision logic for one word.
// ----------------------------------------------------------------------------
`default_nettype none

module updd_engine
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire logic [1:0]        op,
    input  wire logic [7:0]        rx_byte,
    input  wire logic [1:0]        mode,
    input  wire logic [15:0]       timeout,
    input  wire logic              mode_write,
    output logic                   res_valid,
    output updd_pkg::updd_res_t    res
);
    import updd_pkg::*;

    logic [1:0]  proto_reg, proto_next;
    logic [1:0]  phase_reg, phase_next;
    logic [15:0] age_reg, age_next;
    logic [8:0]  count_reg, count_next;
    logic [8:0]  total_reg, total_next;
    logic [7:0]  head0_reg, head0_next;
    logic [7:0]  head1_reg, head1_next;

    logic [1:0]  proto_cur;
    logic [7:0]  h0;
    logic [7:0]  h1;
    logic [9:0]  count_inc;
    logic [8:0]  total_i;
    logic [8:0]  total_use;
    logic [9:0]  i_len;
    logic        is_s_reg;

    assign proto_cur = (mode == PROTO_I || mode == PROTO_S) ? mode : proto_reg;
    assign count_inc = {1'b0, count_reg} + 10'd1;
    assign h0        = (count_reg == 9'd0) ? rx_byte : head0_reg;
    assign h1        = (count_reg == 9'd1) ? rx_byte : head1_reg;
    assign i_len     = {2'b00, rx_byte} + 10'd2;
    // length byte of zero still makes a three-byte frame
    assign total_i   = (i_len < {1'b0, I_MIN_LEN}) ? I_MIN_LEN : i_len[8:0];
    assign is_s_reg  = h0 == S_REG_SHORT_A || h0 == S_REG_53 || h0 == S_REG_54
                    || h0 == S_REG_55 || h0 == S_REG_SHORT_B;

    always_comb
    begin
        proto_next = proto_reg;
        phase_next = phase_reg;
        age_next   = age_reg;
        count_next = count_reg;
        total_next = total_reg;
        head0_next = head0_reg;
        head1_next = head1_reg;
        res_valid  = 1'b0;
        res        = '{ev: EV_PROBE_I, proto: proto_cur, registry: 8'd0, data: 8'd0,
                       index: 9'd0, last: 1'b0};
        total_use  = total_reg;

        case (op)
            OP_TICK:
            begin
                if (age_reg != 16'hFFFF)
                begin
                    age_next = age_reg + 16'd1;
                end
            end
            OP_SEND:
            begin
                if (proto_cur == PROTO_NONE)
                begin
                    if (phase_reg == PHASE_NONE)
                    begin
                        phase_next = PHASE_I_SENT;
                        age_next   = 16'd0;
                        res_valid  = 1'b1;
                        res.ev     = EV_PROBE_I;
                    end
                    else if (age_reg > timeout)
                    begin
                        res_valid = 1'b1;
                        if (phase_reg == PHASE_I_SENT)
                        begin
                            phase_next = PHASE_S_SENT;
                            age_next   = 16'd0;
                            res.ev     = EV_PROBE_S;
                        end
                        else
                        begin
                            // second timeout falls back to I
                            proto_next = PROTO_I;
                            phase_next = PHASE_NONE;
                            count_next = 9'd0;
                            total_next = 9'd0;
                            res.ev     = EV_RESOLVED;
                            res.proto  = PROTO_I;
                        end
                    end
                end
            end
            OP_RX:
            begin
                if (proto_cur == PROTO_NONE)
                begin
                    if (phase_reg == PHASE_NONE)
                    begin
                        count_next = 9'd0;
                        total_next = 9'd0;
                    end
                    else if (count_reg < 9'd3)
                    begin
                        head0_next = h0;
                        head1_next = h1;
                        count_next = count_inc[8:0];
                        if (count_inc >= 10'd2 && h0 == REJ_FIRST && h1 == REJ_SECOND)
                        begin
                            res_valid  = 1'b1;
                            res.proto  = (phase_reg == PHASE_I_SENT) ? PROTO_S : PROTO_I;
                        end
                        else if (count_inc >= 10'd3 && h0 == I_HEADER)
                        begin
                            res_valid = 1'b1;
                            res.proto = PROTO_I;
                        end
                        else if (phase_reg == PHASE_S_SENT && is_s_reg)
                        begin
                            res_valid = 1'b1;
                            res.proto = PROTO_S;
                        end
                        if (res_valid)
                        begin
                            res.ev     = EV_RESOLVED;
                            proto_next = res.proto;
                            phase_next = PHASE_NONE;
                            count_next = 9'd0;
                            total_next = 9'd0;
                        end
                    end
                end
                else if (count_reg == 9'd0)
                begin
                    head0_next = rx_byte;
                    count_next = 9'd1;
                    total_next = (rx_byte == S_REG_SHORT_A || rx_byte == S_REG_SHORT_B)
                               ? S_SHORT_LEN : S_LONG_LEN;
                end
                else if (count_reg == 9'd1 && head0_reg == REJ_FIRST && rx_byte == REJ_SECOND)
                begin
                    count_next = 9'd0;
                    total_next = 9'd0;
                    res_valid  = 1'b1;
                    res.ev     = EV_REJECT;
                end
                else if (proto_cur == PROTO_I && count_reg == 9'd1)
                begin
                    head1_next = rx_byte;
                    count_next = 9'd2;
                end
                else if (proto_cur == PROTO_I && count_reg == 9'd2 && head0_reg != I_HEADER)
                begin
                    count_next = 9'd0;
                    total_next = 9'd0;
                    res_valid  = 1'b1;
                    res.ev     = EV_HDR_ERR;
                end
                else
                begin
                    // frame byte: I frames take the length at index two
                    if (proto_cur == PROTO_I && count_reg == 9'd2)
                    begin
                        total_use = total_i;
                    end
                    res_valid    = 1'b1;
                    res.ev       = EV_BYTE;
                    res.registry = (proto_cur == PROTO_S) ? head0_reg : head1_reg;
                    res.data     = rx_byte;
                    res.index    = count_reg;
                    res.last     = count_inc >= {1'b0, total_use};
                    if (res.last)
                    begin
                        count_next = 9'd0;
                        total_next = 9'd0;
                    end
                    else
                    begin
                        count_next = count_inc[8:0];
                        total_next = total_use;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proto_reg <= PROTO_NONE;
            phase_reg <= PHASE_NONE;
            age_reg   <= 16'd0;
            count_reg <= 9'd0;
            total_reg <= 9'd0;
        end
        else if (mode_write)
        begin
            count_reg <= 9'd0;
            total_reg <= 9'd0;
        end
        else if (fire)
        begin
            proto_reg <= proto_next;
            phase_reg <= phase_next;
            age_reg   <= age_next;
            count_reg <= count_next;
            total_reg <= total_next;
        end
    end

    // header bytes are only read after being written in the same frame
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            head0_reg <= head0_next;
            head1_reg <= head1_next;
        end
    end

endmodule

`default_nettype wire
